// ===== design/mbrt_pkg.sv =====
`timescale 1ns / 1ps

package mbrt_pkg;

   // Frame geometry
   localparam int FRAME_BYTES    = 8;
   localparam int FRAME_IDX_BITS = $clog2(FRAME_BYTES);
   localparam int COUNT_BITS     = $clog2(FRAME_BYTES + 1);
   localparam int HDR_BYTES      = 6;
   localparam int READ_LEN       = 7;
   localparam logic [7:0] READ_BYTE_COUNT = 8'(READ_LEN - 5);

   // Command codes on the request channel
   localparam logic [1:0] CMD_ISSUE = 2'd0;
   localparam logic [1:0] CMD_RX    = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Function codes
   localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;
   localparam logic [7:0] FUNC_READ_INPUT   = 8'd4;
   localparam logic [15:0] READ_REG_COUNT   = 16'h0001;

   // CRC-16 (reflected)
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd254;

   // Result kinds
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Completion error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_LENGTH     = 3'd1;
   localparam logic [2:0] ERR_SHORT      = 3'd2;
   localparam logic [2:0] ERR_CRC        = 3'd3;
   localparam logic [2:0] ERR_ADDRESS    = 3'd4;
   localparam logic [2:0] ERR_FUNCTION   = 3'd5;
   localparam logic [2:0] ERR_BYTE_COUNT = 3'd6;
   localparam logic [2:0] ERR_ECHO       = 3'd7;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  func_code;
      logic [15:0] reg_addr;
      logic [15:0] request_value;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic               out_kind;
      logic [7:0]         tx_byte;
      logic               last;
      logic               ok;
      logic [2:0]         error_code;
      logic signed [15:0] read_value;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_ISSUE,
      OP_RX,
      OP_END
   } op_kind_type;

   // Classified operation passed from front to back
   typedef struct packed {
      op_kind_type kind;
      logic        read_func;
      logic [7:0]  func_code;
      logic [15:0] reg_addr;
      logic [15:0] value;
      logic [7:0]  rx_byte;
   } op_type;

   // One byte of the running CRC, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/modbus_rtu_register_transaction.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// request   push / full                req_item  (mbrt_pkg::req_item_type)
// result    empty / pop                rsp_item  (mbrt_pkg::rsp_item_type)
// csr       csr_valid / csr_ready      csr_data  (slave address, 8 bits)
//
// One request transaction can be taken every cycle while the command queue has room.
// The back end takes a received byte or an end command as one operation and an issue as
// eight transmit bytes, one per cycle while results have room; its result path sets the rate.
// Reset is synchronous: queues empty, slave address 254, request frame cleared.
// A low pop fills the result queue, then stalls the back end, then the command
// queue, and full rises only once the command queue is full.

module modbus_rtu_register_transaction #(
   parameter int CMD_QUEUE_DEPTH = 4,
   parameter int RSP_QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbrt_pkg::req_item_type req_item,
   output logic                   full,
   output logic                   empty,
   input  logic                   pop,
   output mbrt_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);

   localparam int OP_BITS  = $bits(mbrt_pkg::op_type);
   localparam int RSP_BITS = $bits(mbrt_pkg::rsp_item_type);

   mbrt_pkg::op_type       op_in, op_out;
   mbrt_pkg::rsp_item_type res;
   logic                   op_push, op_full, op_pop, op_empty;
   logic                   res_valid, res_full;
   logic [OP_BITS-1:0]     op_rd_data;
   logic [RSP_BITS-1:0]    rsp_rd_data;
   logic [7:0]             device_address;

   // Accept and classify
   mbrt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .req_item       (req_item),
      .full           (full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .op_full        (op_full),
      .op_push        (op_push),
      .op             (op_in),
      .device_address (device_address)
   );

   // Decouple front from back
   mbrt_queue #(
      .WIDTH (OP_BITS),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (OP_BITS'(op_in)),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_rd_data),
      .empty     (op_empty)
   );

   assign op_out = mbrt_pkg::op_type'(op_rd_data);

   // Carry out transactions
   mbrt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .device_address (device_address),
      .op_valid       (~op_empty),
      .op             (op_out),
      .op_pop         (op_pop),
      .res_ready      (~res_full),
      .res_valid      (res_valid),
      .res            (res)
   );

   // Buffer results for the consumer
   mbrt_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (RSP_BITS'(res)),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_rd_data),
      .empty     (empty)
   );

   assign rsp_item = mbrt_pkg::rsp_item_type'(rsp_rd_data);

endmodule

// ===== design/mbrt_queue.sv =====
`timescale 1ns / 1ps

module mbrt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push & ~full;
   assign pop_ok   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mbrt_front.sv =====
`timescale 1ns / 1ps

module mbrt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mbrt_pkg::req_item_type req_item,
   output logic                  full,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data,
   input  logic                  op_full,
   output logic                  op_push,
   output mbrt_pkg::op_type      op,
   output logic [7:0]            device_address
);

   logic [7:0] device_address_ff, device_address_in;
   logic       keep;

   assign full           = op_full;
   assign csr_ready      = 1'b1;
   assign device_address = device_address_ff;

   // Hold the slave address register
   always_comb begin
      device_address_in = device_address_ff;
      if (csr_valid) begin
         device_address_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= mbrt_pkg::DEVICE_ADDRESS_RESET;
      end else begin
         device_address_ff <= device_address_in;
      end
   end

   // Classify the transaction; drop unused command codes
   always_comb begin
      op.read_func = (req_item.func_code == mbrt_pkg::FUNC_READ_HOLDING) ||
                     (req_item.func_code == mbrt_pkg::FUNC_READ_INPUT);
      op.func_code = req_item.func_code;
      op.reg_addr  = req_item.reg_addr;
      op.value     = op.read_func ? mbrt_pkg::READ_REG_COUNT : req_item.request_value;
      op.rx_byte   = req_item.rx_byte;
      op.kind      = mbrt_pkg::OP_ISSUE;
      keep         = 1'b1;
      unique case (req_item.cmd)
         mbrt_pkg::CMD_ISSUE: op.kind = mbrt_pkg::OP_ISSUE;
         mbrt_pkg::CMD_RX:    op.kind = mbrt_pkg::OP_RX;
         mbrt_pkg::CMD_END:   op.kind = mbrt_pkg::OP_END;
         default:             keep    = 1'b0;
      endcase
   end

   assign op_push = push & ~op_full & keep;

endmodule

// ===== design/mbrt_back.sv =====
`timescale 1ns / 1ps

module mbrt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             device_address,
   input  logic                   op_valid,
   input  mbrt_pkg::op_type       op,
   output logic                   op_pop,
   input  logic                   res_ready,
   output logic                   res_valid,
   output mbrt_pkg::rsp_item_type res
);

   localparam int IB = mbrt_pkg::FRAME_IDX_BITS;
   localparam int CB = mbrt_pkg::COUNT_BITS;
   localparam int SHIFT_BITS = 8 * (mbrt_pkg::HDR_BYTES - 1);

   // Transmit sequencer
   logic                  busy_ff, busy_in;
   logic [IB-1:0]         tx_idx_ff, tx_idx_in;
   logic [SHIFT_BITS-1:0] tx_shift_ff, tx_shift_in;
   logic [15:0]           tx_crc_ff, tx_crc_in;

   // Request and reply state
   logic [7:0]    sent_ff [mbrt_pkg::FRAME_BYTES];
   logic [7:0]    reply_ff [mbrt_pkg::FRAME_BYTES];
   logic [CB-1:0] reply_count_ff, reply_count_in;
   logic [7:0]    pending_func_ff, pending_func_in;
   logic          pending_read_ff, pending_read_in;
   logic [15:0]   reply_crc_ff, reply_crc_in;

   logic [8*mbrt_pkg::HDR_BYTES-1:0] hdr;
   logic        start_issue, do_end, do_rx, tx_step, rx_store;
   logic [7:0]  tx_cur;
   logic [15:0] tx_crc_upd;
   logic [CB-1:0] expect_len;
   logic        sent_match;
   logic [2:0]  err;
   logic signed [15:0] value;

   assign hdr = {device_address, op.func_code, op.reg_addr, op.value};

   // Decide what the back end does this cycle
   assign tx_step     = busy_ff & res_ready;
   assign start_issue = ~busy_ff & op_valid & (op.kind == mbrt_pkg::OP_ISSUE) & res_ready;
   assign do_end      = ~busy_ff & op_valid & (op.kind == mbrt_pkg::OP_END) & res_ready;
   assign do_rx       = ~busy_ff & op_valid & (op.kind == mbrt_pkg::OP_RX);
   assign op_pop      = start_issue | do_end | do_rx;

   // Select the byte to send and fold it into the request CRC
   always_comb begin
      if (!busy_ff) begin
         tx_cur = hdr[8*mbrt_pkg::HDR_BYTES-1 -: 8];
      end else if (tx_idx_ff < IB'(mbrt_pkg::HDR_BYTES)) begin
         tx_cur = tx_shift_ff[SHIFT_BITS-1 -: 8];
      end else if (tx_idx_ff == IB'(mbrt_pkg::HDR_BYTES)) begin
         tx_cur = tx_crc_ff[7:0];
      end else begin
         tx_cur = tx_crc_ff[15:8];
      end
      tx_crc_upd = mbrt_pkg::crc_byte(busy_ff ? tx_crc_ff : mbrt_pkg::CRC_INIT, tx_cur);
   end

   // Check the reply on end of reception
   always_comb begin
      expect_len = pending_read_ff ? CB'(mbrt_pkg::READ_LEN) : CB'(mbrt_pkg::FRAME_BYTES);
      sent_match = 1'b1;
      for (int i = 0; i < mbrt_pkg::FRAME_BYTES; i++) begin
         if (sent_ff[i] != reply_ff[i]) begin
            sent_match = 1'b0;
         end
      end
      err   = mbrt_pkg::ERR_NONE;
      value = '0;
      if (pending_read_ff) begin
         if (reply_count_ff != CB'(mbrt_pkg::READ_LEN)) begin
            err = mbrt_pkg::ERR_LENGTH;
         end else if (reply_crc_ff != 16'h0000) begin
            err = mbrt_pkg::ERR_CRC;
         end else if (reply_ff[0] != device_address) begin
            err = mbrt_pkg::ERR_ADDRESS;
         end else if (reply_ff[1] != pending_func_ff) begin
            err = mbrt_pkg::ERR_FUNCTION;
         end else if (reply_ff[2] != mbrt_pkg::READ_BYTE_COUNT) begin
            err = mbrt_pkg::ERR_BYTE_COUNT;
         end else begin
            value = $signed({reply_ff[3], reply_ff[4]});
         end
      end else begin
         if (reply_count_ff != CB'(mbrt_pkg::FRAME_BYTES)) begin
            err = mbrt_pkg::ERR_LENGTH;
         end else if (!sent_match) begin
            err = mbrt_pkg::ERR_ECHO;
         end
      end
   end

   // Build the result transaction
   always_comb begin
      res_valid = tx_step | start_issue | do_end;
      if (do_end) begin
         res.out_kind   = mbrt_pkg::KIND_STATUS;
         res.tx_byte    = 8'h00;
         res.last       = 1'b1;
         res.ok         = (err == mbrt_pkg::ERR_NONE);
         res.error_code = err;
         res.read_value = value;
      end else begin
         res.out_kind   = mbrt_pkg::KIND_TX;
         res.tx_byte    = tx_cur;
         res.last       = busy_ff && (tx_idx_ff == IB'(mbrt_pkg::FRAME_BYTES - 1));
         res.ok         = 1'b0;
         res.error_code = mbrt_pkg::ERR_NONE;
         res.read_value = '0;
      end
   end

   assign rx_store = do_rx && (reply_count_ff < expect_len);

   // Next state of sequencer and reply tracking
   always_comb begin
      busy_in         = busy_ff;
      tx_idx_in       = tx_idx_ff;
      tx_shift_in     = tx_shift_ff;
      tx_crc_in       = tx_crc_ff;
      reply_count_in  = reply_count_ff;
      pending_func_in = pending_func_ff;
      pending_read_in = pending_read_ff;
      reply_crc_in    = reply_crc_ff;
      if (start_issue) begin
         busy_in         = 1'b1;
         tx_idx_in       = IB'(1);
         tx_shift_in     = hdr[SHIFT_BITS-1:0];
         tx_crc_in       = tx_crc_upd;
         pending_func_in = op.func_code;
         pending_read_in = op.read_func;
         reply_count_in  = '0;
         reply_crc_in    = mbrt_pkg::CRC_INIT;
      end else if (tx_step) begin
         tx_idx_in   = tx_idx_ff + 1'b1;
         tx_shift_in = tx_shift_ff << 8;
         if (tx_idx_ff < IB'(mbrt_pkg::HDR_BYTES)) begin
            tx_crc_in = tx_crc_upd;
         end
         if (tx_idx_ff == IB'(mbrt_pkg::FRAME_BYTES - 1)) begin
            busy_in = 1'b0;
         end
      end else if (rx_store) begin
         reply_count_in = reply_count_ff + 1'b1;
         reply_crc_in   = mbrt_pkg::crc_byte(reply_crc_ff, op.rx_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         tx_idx_ff       <= '0;
         reply_count_ff  <= '0;
         pending_func_ff <= 8'h00;
         pending_read_ff <= 1'b0;
         reply_crc_ff    <= mbrt_pkg::CRC_INIT;
         for (int i = 0; i < mbrt_pkg::FRAME_BYTES; i++) begin
            sent_ff[i] <= 8'h00;
         end
      end else begin
         busy_ff         <= busy_in;
         tx_idx_ff       <= tx_idx_in;
         reply_count_ff  <= reply_count_in;
         pending_func_ff <= pending_func_in;
         pending_read_ff <= pending_read_in;
         reply_crc_ff    <= reply_crc_in;
         if (start_issue) begin
            sent_ff[0] <= tx_cur;
         end else if (tx_step) begin
            sent_ff[tx_idx_ff] <= tx_cur;
         end
      end
   end

   // Hold the transmit shift line, CRC and reply bytes
   always_ff @(posedge clock) begin
      tx_shift_ff <= tx_shift_in;
      tx_crc_ff   <= tx_crc_in;
      if (rx_store) begin
         reply_ff[reply_count_ff[IB-1:0]] <= op.rx_byte;
      end
   end

endmodule

// ===== tb/tb_modbus_rtu_register_transaction.sv =====
`timescale 1ns / 1ps

module tb_modbus_rtu_register_transaction;
   import mbrt_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 205;
   localparam int PHASES         = 5;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 1200;
   localparam int HOLD_AFTER     = 80;
   localparam int HOLD_CYCLES    = 300;

   // Where a directed receive byte comes from
   typedef enum {SRC_LIT, SRC_ECHO, SRC_CRC_LO, SRC_CRC_HI} rx_src_type;

   // Ways a random reply frame is spoilt
   typedef enum {REPLY_GOOD, REPLY_BAD_ADDR, REPLY_BAD_FUNC, REPLY_BAD_COUNT,
                 REPLY_BAD_BYTE, REPLY_SHORT, REPLY_EXTRA} reply_shape_type;

   typedef struct {
      req_item_type item;
      rx_src_type   src;
      bit           typed;
      rsp_item_type result;
   } script_row_type;

   logic          clock;
   logic          reset;
   logic          push;
   req_item_type  req_item;
   logic          full;
   logic          empty;
   logic          pop;
   rsp_item_type  rsp_item;
   logic          csr_valid;
   logic          csr_ready;
   logic [7:0]    csr_data;

   // Predicted master state
   logic [7:0]    m_addr = DEVICE_ADDRESS_RESET;
   logic [7:0]    m_sent [FRAME_BYTES] = '{default: 8'h00};
   logic [7:0]    m_reply [FRAME_BYTES] = '{default: 8'h00};
   int            m_count = 0;
   logic [7:0]    m_func = 8'h00;
   logic [15:0]   m_crc = CRC_INIT;

   rsp_item_type  awaited_rsp [$];
   script_row_type script_rows [$];

   int n_errors = 0;
   int n_items = 0;
   int n_results = 0;
   int n_done = 0;
   int n_clean = 0;
   int n_addr_writes = 0;
   int quiet = 0;
   bit held_off = 1'b0;

   modbus_rtu_register_transaction DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_item  (req_item),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // One byte into a reflected CRC-16
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] s;
      s = acc ^ {8'h00, data};
      repeat (8) s = s[0] ? ((s >> 1) ^ CRC_POLY) : (s >> 1);
      return s;
   endfunction

   function automatic bit is_read_code(input logic [7:0] f);
      return f == FUNC_READ_HOLDING || f == FUNC_READ_INPUT;
   endfunction

   // Mostly no gap, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rsp_item_type status_item(input bit good, input logic [2:0] code,
                                                input logic [15:0] value);
      rsp_item_type r;
      r = '0;
      r.out_kind   = KIND_STATUS;
      r.last       = 1'b1;
      r.ok         = good;
      r.error_code = code;
      r.read_value = value;
      return r;
   endfunction

   function automatic script_row_type row(input logic [1:0] cmd, input logic [7:0] f,
                                          input logic [15:0] ra, input logic [15:0] v,
                                          input logic [7:0] b, input rx_src_type src = SRC_LIT,
                                          input bit typed = 1'b0,
                                          input rsp_item_type result = '0);
      script_row_type s;
      s.item   = '{cmd: cmd, func_code: f, reg_addr: ra, request_value: v, rx_byte: b};
      s.src    = src;
      s.typed  = typed;
      s.result = result;
      return s;
   endfunction

   function automatic req_item_type rand_item(input logic [1:0] cmd);
      req_item_type it;
      it.cmd           = cmd;
      it.func_code     = 8'($urandom);
      it.reg_addr      = 16'($urandom);
      it.request_value = 16'($urandom);
      it.rx_byte       = 8'($urandom);
      return it;
   endfunction

   // Work out the results of one accepted request transaction
   task automatic predict_master(input req_item_type it);
      rsp_item_type r;
      logic [15:0]  v;
      logic [15:0]  c;
      logic [2:0]   code;
      case (it.cmd)
         CMD_ISSUE: begin
            v = is_read_code(it.func_code) ? READ_REG_COUNT : it.request_value;
            m_sent[0] = m_addr;
            m_sent[1] = it.func_code;
            m_sent[2] = it.reg_addr[15:8];
            m_sent[3] = it.reg_addr[7:0];
            m_sent[4] = v[15:8];
            m_sent[5] = v[7:0];
            c = CRC_INIT;
            for (int i = 0; i < HDR_BYTES; i++) c = crc16_step(c, m_sent[i]);
            m_sent[6] = c[7:0];
            m_sent[7] = c[15:8];
            m_func  = it.func_code;
            m_count = 0;
            m_crc   = CRC_INIT;
            for (int i = 0; i < FRAME_BYTES; i++) begin
               r = '0;
               r.out_kind = KIND_TX;
               r.tx_byte  = m_sent[i];
               r.last     = (i == FRAME_BYTES - 1);
               awaited_rsp.push_back(r);
            end
         end
         CMD_RX: begin
            // drop bytes beyond the expected reply length
            if (m_count < (is_read_code(m_func) ? READ_LEN : FRAME_BYTES)) begin
               m_reply[m_count] = it.rx_byte;
               m_count++;
               m_crc = crc16_step(m_crc, it.rx_byte);
            end
         end
         CMD_END: begin
            r = status_item(1'b0, ERR_NONE, 16'h0000);
            code = ERR_NONE;
            if (is_read_code(m_func)) begin
               if (m_count != READ_LEN) code = ERR_LENGTH;
               else if (m_crc != 16'h0000) code = ERR_CRC;
               else if (m_reply[0] != m_addr) code = ERR_ADDRESS;
               else if (m_reply[1] != m_func) code = ERR_FUNCTION;
               else if (m_reply[2] != READ_BYTE_COUNT) code = ERR_BYTE_COUNT;
               else r.read_value = {m_reply[3], m_reply[4]};
            end else begin
               if (m_count != FRAME_BYTES) code = ERR_LENGTH;
               else for (int i = 0; i < FRAME_BYTES; i++)
                  if (m_reply[i] != m_sent[i]) code = ERR_ECHO;
            end
            r.error_code = code;
            r.ok         = (code == ERR_NONE);
            awaited_rsp.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Offer one request transaction and predict it once taken
   task automatic send_req(input req_item_type it, input bit typed = 1'b0,
                           input rsp_item_type result = '0);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (full);
      predict_master(it);
      if (typed) begin
         void'(awaited_rsp.pop_back());
         awaited_rsp.push_back(result);
      end
      if (it.cmd != CMD_UNUSED) n_items++;
   endtask

   task automatic send_rx(input logic [7:0] b);
      req_item_type it;
      it = rand_item(CMD_RX);
      it.rx_byte = b;
      send_req(it);
   endtask

   // Write the slave address once the block has gone quiet
   task automatic write_slave_address(input logic [7:0] value);
      push <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      m_addr = value;
      n_addr_writes++;
      csr_valid <= 1'b0;
   endtask

   // One issue, a reply that is mostly well formed, and an end; now and then stray items before or a second end after
   task automatic random_exchange();
      req_item_type    it;
      logic [7:0]      f;
      logic [7:0]      frame [$];
      logic [15:0]     c;
      reply_shape_type shape;
      int              r;
      int              n;
      r = $urandom_range(0, 9);
      if (r < 4) f = ($urandom_range(0, 1) != 0) ? FUNC_READ_HOLDING : FUNC_READ_INPUT;
      else if (r < 8) f = 8'd6;
      else f = 8'($urandom);
      // stray bytes or an unused command ahead of the issue
      if ($urandom_range(0, 9) == 0) send_rx(8'($urandom));
      if ($urandom_range(0, 11) == 0) send_req(rand_item(CMD_UNUSED));
      it = rand_item(CMD_ISSUE);
      it.func_code = f;
      send_req(it);
      shape = ($urandom_range(0, 9) < 6) ? REPLY_GOOD
                                          : reply_shape_type'($urandom_range(1, 6));
      if (is_read_code(f)) begin
         frame.push_back(m_addr);
         frame.push_back(f);
         frame.push_back(READ_BYTE_COUNT);
         frame.push_back(8'($urandom));
         frame.push_back(8'($urandom));
         case (shape)
            REPLY_BAD_ADDR:  frame[0] ^= 8'($urandom_range(1, 255));
            REPLY_BAD_FUNC:  frame[1] ^= 8'($urandom_range(1, 255));
            REPLY_BAD_COUNT: frame[2] ^= 8'($urandom_range(1, 255));
            default: ;
         endcase
         c = CRC_INIT;
         foreach (frame[i]) c = crc16_step(c, frame[i]);
         frame.push_back(c[7:0]);
         frame.push_back(c[15:8]);
      end else begin
         for (int i = 0; i < FRAME_BYTES; i++) frame.push_back(m_sent[i]);
         if (shape inside {REPLY_BAD_ADDR, REPLY_BAD_FUNC, REPLY_BAD_COUNT})
            shape = REPLY_BAD_BYTE;
      end
      case (shape)
         REPLY_BAD_BYTE: begin
            n = $urandom_range(0, frame.size() - 1);
            frame[n] ^= 8'($urandom_range(1, 255));
         end
         REPLY_SHORT: begin
            n = $urandom_range(0, frame.size() - 1);
            while (frame.size() > n) void'(frame.pop_back());
         end
         REPLY_EXTRA: repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
         default: ;
      endcase
      foreach (frame[i]) send_rx(frame[i]);
      send_req(rand_item(CMD_END));
      if ($urandom_range(0, 7) == 0) send_req(rand_item(CMD_END));
   endtask

   // Compare one field of a result
   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         n_errors++;
      end
   endfunction

   // Check each result transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && pop && !empty) begin
         n_results++;
         if (awaited_rsp.size() == 0) begin
            $error("result with nothing awaited: kind %0d tx %0h err %0d",
                   rsp_item.out_kind, rsp_item.tx_byte, rsp_item.error_code);
            n_errors++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("out_kind", want.out_kind, rsp_item.out_kind);
            check_field("tx_byte", want.tx_byte, rsp_item.tx_byte);
            check_field("last", want.last, rsp_item.last);
            check_field("ok", want.ok, rsp_item.ok);
            check_field("error_code", want.error_code, rsp_item.error_code);
            check_field("read_value", want.read_value, rsp_item.read_value);
            if (want.out_kind == KIND_STATUS) begin
               n_done++;
               if (want.ok) n_clean++;
            end
         end
      end
   end

   // Give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results awaited",
                  quiet, awaited_rsp.size());
         $display("tb_modbus_rtu_register_transaction: errors");
         $finish;
      end
   end

   // Result side: random stalls, and one long hold-off to back up the input
   initial begin
      int stall;
      pop = 1'b0;
      wait (!reset);
      forever begin
         if (!held_off && n_results >= HOLD_AFTER) begin
            held_off = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = idle_len();
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      req_item_type   it;
      script_row_type s;
      logic [15:0]    crc_snap;
      logic [7:0]     addr_plan [PHASES];
      int             random_start;
      reset     = 1'b1;
      push      = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_data  = 8'h00;
      crc_snap  = CRC_INIT;

      // Directed script at the reset slave address
      script_rows.push_back(row(CMD_END, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_LIT, 1'b1,
                                status_item(1'b0, ERR_LENGTH, 16'h0000)));
      script_rows.push_back(row(CMD_END, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, SRC_LIT, 1'b1,
                                status_item(1'b0, ERR_LENGTH, 16'h0000)));
      script_rows.push_back(row(CMD_ISSUE, FUNC_READ_HOLDING, 16'hFFFF, 16'hABCD, 8'h00));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, DEVICE_ADDRESS_RESET));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, FUNC_READ_HOLDING));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, READ_BYTE_COUNT));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, 8'h80));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, 8'h00));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_CRC_LO));
      script_rows.push_back(row(CMD_END, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_LIT, 1'b1,
                                status_item(1'b0, ERR_LENGTH, 16'h0000)));
      // the last byte lands after the end and still counts
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_CRC_HI));
      script_rows.push_back(row(CMD_RX, 8'h00, 16'h0000, 16'h0000, 8'h55));
      script_rows.push_back(row(CMD_END, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_LIT, 1'b1,
                                status_item(1'b1, ERR_NONE, 16'h8000)));
      // an odd function code takes the write path
      script_rows.push_back(row(CMD_ISSUE, 8'hFF, 16'h0000, 16'h0000, 8'hFF));
      repeat (FRAME_BYTES)
         script_rows.push_back(row(CMD_RX, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, SRC_ECHO));
      script_rows.push_back(row(CMD_END, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_LIT, 1'b1,
                                status_item(1'b1, ERR_NONE, 16'h0000)));
      script_rows.push_back(row(CMD_ISSUE, FUNC_READ_INPUT, 16'h1234, 16'hFFFF, 8'h00));
      script_rows.push_back(row(CMD_UNUSED, 8'h06, 16'h5A5A, 16'hA5A5, 8'hAA));
      script_rows.push_back(row(CMD_END, 8'h00, 16'h0000, 16'h0000, 8'h00, SRC_LIT, 1'b1,
                                status_item(1'b0, ERR_LENGTH, 16'h0000)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Walk the script, filling in bytes that depend on the frame so far
      foreach (script_rows[i]) begin
         s  = script_rows[i];
         it = s.item;
         case (s.src)
            SRC_ECHO:   it.rx_byte = m_sent[m_count];
            SRC_CRC_LO: begin
               crc_snap   = m_crc;
               it.rx_byte = crc_snap[7:0];
            end
            SRC_CRC_HI: it.rx_byte = crc_snap[15:8];
            default: ;
         endcase
         send_req(it, s.typed, s.result);
      end

      // Random exchanges, one slave address per phase
      addr_plan[0] = 8'h00;
      addr_plan[1] = 8'hFF;
      addr_plan[2] = 8'($urandom);
      addr_plan[3] = 8'h01;
      addr_plan[4] = 8'($urandom);
      random_start = n_items;
      for (int p = 0; p < PHASES; p++) begin
         write_slave_address(addr_plan[p]);
         while (n_items - random_start < (p + 1) * RANDOM_ITEMS / PHASES) random_exchange();
      end

      // Drain the results, then leave room for strays
      push <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request transactions, %0d results, %0d slave address writes",
               n_items, n_results, n_addr_writes);
      $display("%0d completions checked, %0d of them clean replies", n_done, n_clean);
      if (n_errors == 0) begin
         $display("tb_modbus_rtu_register_transaction: clean");
      end else begin
         $display("tb_modbus_rtu_register_transaction: errors");
      end
      $finish;
   end

endmodule
